// ===== hdl/wsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants of the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int unsigned BufSizeWidth = 21;
  localparam logic [BufSizeWidth-1:0] BufSizeReset = 21'd4096;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);
  localparam int unsigned QueueCw    = $clog2(QueueDepth + 1);

  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  typedef enum logic [2:0] {
    KIND_DATA     = 3'd0,
    KIND_PING     = 3'd1,
    KIND_CLOSE    = 3'd2,
    KIND_FRAG     = 3'd3,
    KIND_UNKNOWN  = 3'd4,
    KIND_OVERFLOW = 3'd5
  } kind_e;

  // one classified item travelling from the parser to the emitter
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic [7:0] key;
    logic       has_byte;
    logic       binary;
    logic       last;
  } cmd_t;

endpackage

// ===== hdl/wsd_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_parser
// Front end: walks the frame header byte by byte, checks it, and classifies
// each data or ping payload byte into an item for the result queue.
// ----------------------------------------------------------------------------
module wsd_parser (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               accept_i,
  input  logic [7:0]                         rx_byte_i,
  input  logic                               buffer_size_we_i,
  input  logic [wsd_pkg::BufSizeWidth-1:0]   buffer_size_i,
  output logic                               emit_o,
  output wsd_pkg::cmd_t                      cmd_o
);

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_SECOND,
    PH_EXTLEN,
    PH_MASK,
    PH_PAYLOAD,
    PH_HALT
  } phase_e;

  typedef enum logic [1:0] {
    ACT_SKIP,
    ACT_DATA,
    ACT_PING
  } action_e;

  phase_e                           phase_q, phase_d;
  action_e                          act_q, act_d;
  logic [3:0]                       left_q, left_d;
  logic [3:0]                       total_q, total_d;
  logic [3:0]                       opcode_q, opcode_d;
  logic                             final_q, final_d;
  logic                             masked_q, masked_d;
  logic [63:0]                      rem_q, rem_d;
  logic [31:0]                      key_q, key_d;
  logic [1:0]                       mpos_q, mpos_d;
  logic                             frag_q, frag_d;
  logic                             bin_q, bin_d;
  logic [wsd_pkg::BufSizeWidth-1:0] buf_q;

  logic                             after_len;
  logic                             hdr_done;
  logic                             ovf;
  logic                             last_pay;
  logic [7:0]                       key_byte;
  logic [wsd_pkg::BufSizeWidth:0]   need;

  always_comb begin
    phase_d   = phase_q;
    act_d     = act_q;
    left_d    = left_q;
    total_d   = total_q;
    opcode_d  = opcode_q;
    final_d   = final_q;
    masked_d  = masked_q;
    rem_d     = rem_q;
    key_d     = key_q;
    mpos_d    = mpos_q;
    frag_d    = frag_q;
    bin_d     = bin_q;
    after_len = 1'b0;
    hdr_done  = 1'b0;
    ovf       = 1'b0;
    need      = '0;
    last_pay  = (rem_q == 64'd1);
    emit_o    = 1'b0;
    cmd_o     = '0;

    case (mpos_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase

    if (accept_i) begin
      case (phase_q)
        PH_FIRST: begin
          final_d  = rx_byte_i[7];
          opcode_d = rx_byte_i[3:0];
          key_d    = '0;
          mpos_d   = '0;
          rem_d    = '0;
          total_d  = 4'd2;
          phase_d  = PH_SECOND;
        end
        PH_SECOND: begin
          masked_d = rx_byte_i[7];
          if (rx_byte_i[6:0] == wsd_pkg::LEN_EXT16) begin
            left_d  = 4'd2;
            total_d = total_q + 4'd2;
            phase_d = PH_EXTLEN;
          end else if (rx_byte_i[6:0] == wsd_pkg::LEN_EXT64) begin
            left_d  = 4'd8;
            total_d = total_q + 4'd8;
            phase_d = PH_EXTLEN;
          end else begin
            rem_d     = {57'd0, rx_byte_i[6:0]};
            after_len = 1'b1;
          end
        end
        PH_EXTLEN: begin
          rem_d  = {rem_q[55:0], rx_byte_i};
          left_d = left_q - 4'd1;
          if (left_q == 4'd1) begin
            after_len = 1'b1;
          end
        end
        PH_MASK: begin
          key_d  = {key_q[23:0], rx_byte_i};
          left_d = left_q - 4'd1;
          if (left_q == 4'd1) begin
            hdr_done = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          mpos_d = mpos_q + 2'd1;
          rem_d  = rem_q - 64'd1;
          if (last_pay) begin
            phase_d = PH_FIRST;
          end
          if (act_q == ACT_DATA) begin
            emit_o          = 1'b1;
            cmd_o.kind      = wsd_pkg::KIND_DATA;
            cmd_o.data      = rx_byte_i;
            cmd_o.key       = key_byte;
            cmd_o.has_byte  = 1'b1;
            cmd_o.binary    = bin_q;
            cmd_o.last      = last_pay & final_q;
          end else if (act_q == ACT_PING) begin
            emit_o         = 1'b1;
            cmd_o.kind     = wsd_pkg::KIND_PING;
            cmd_o.data     = rx_byte_i;
            cmd_o.key      = key_byte;
            cmd_o.has_byte = 1'b1;
            cmd_o.last     = last_pay;
          end
        end
        default: ;
      endcase
    end

    if (after_len) begin
      if (masked_d) begin
        left_d  = 4'd4;
        total_d = total_d + 4'd4;
        phase_d = PH_MASK;
      end else begin
        hdr_done = 1'b1;
      end
    end

    if (hdr_done) begin
      need = {1'b0, rem_d[wsd_pkg::BufSizeWidth-1:0]}
           + {{(wsd_pkg::BufSizeWidth-3){1'b0}}, total_d};
      ovf  = (|rem_d[63:wsd_pkg::BufSizeWidth]) || (need > {1'b0, buf_q});
      if (ovf) begin
        phase_d    = PH_HALT;
        emit_o     = 1'b1;
        cmd_o.kind = wsd_pkg::KIND_OVERFLOW;
      end else begin
        phase_d = (rem_d != 64'd0) ? PH_PAYLOAD : PH_FIRST;
        act_d   = ACT_SKIP;
        if (opcode_q == wsd_pkg::OP_CONT || opcode_q == wsd_pkg::OP_TEXT ||
            opcode_q == wsd_pkg::OP_BINARY) begin
          if (opcode_q != wsd_pkg::OP_CONT && frag_q) begin
            emit_o     = 1'b1;
            cmd_o.kind = wsd_pkg::KIND_FRAG;
          end else begin
            if (opcode_q != wsd_pkg::OP_CONT) begin
              bin_d  = (opcode_q == wsd_pkg::OP_BINARY);
              frag_d = ~final_q;
            end else if (final_q) begin
              frag_d = 1'b0;
            end
            act_d = ACT_DATA;
            if (rem_d == 64'd0 && final_q) begin
              emit_o          = 1'b1;
              cmd_o.kind      = wsd_pkg::KIND_DATA;
              cmd_o.binary    = bin_d;
              cmd_o.last      = 1'b1;
            end
          end
        end else if (opcode_q == wsd_pkg::OP_CLOSE) begin
          phase_d    = PH_HALT;
          emit_o     = 1'b1;
          cmd_o.kind = wsd_pkg::KIND_CLOSE;
        end else if (opcode_q == wsd_pkg::OP_PING) begin
          act_d = ACT_PING;
          if (rem_d == 64'd0) begin
            emit_o     = 1'b1;
            cmd_o.kind = wsd_pkg::KIND_PING;
            cmd_o.last = 1'b1;
          end
        end else if (opcode_q != wsd_pkg::OP_PONG) begin
          emit_o     = 1'b1;
          cmd_o.kind = wsd_pkg::KIND_UNKNOWN;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_FIRST;
      act_q    <= ACT_SKIP;
      left_q   <= '0;
      total_q  <= '0;
      opcode_q <= '0;
      final_q  <= 1'b0;
      masked_q <= 1'b0;
      rem_q    <= '0;
      key_q    <= '0;
      mpos_q   <= '0;
      frag_q   <= 1'b0;
      bin_q    <= 1'b0;
      buf_q    <= wsd_pkg::BufSizeReset;
    end else begin
      phase_q  <= phase_d;
      act_q    <= act_d;
      left_q   <= left_d;
      total_q  <= total_d;
      opcode_q <= opcode_d;
      final_q  <= final_d;
      masked_q <= masked_d;
      rem_q    <= rem_d;
      key_q    <= key_d;
      mpos_q   <= mpos_d;
      frag_q   <= frag_d;
      bin_q    <= bin_d;
      if (buffer_size_we_i) begin
        buf_q <= buffer_size_i;
      end
    end
  end

endmodule

// ===== hdl/wsd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_queue
// Short item queue between the parser and the emitter.
// ----------------------------------------------------------------------------
module wsd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  wsd_pkg::cmd_t wr_cmd_i,
  output logic          full_o,
  input  logic          rd_i,
  output logic          valid_o,
  output wsd_pkg::cmd_t rd_cmd_o
);

  wsd_pkg::cmd_t                  mem_q [wsd_pkg::QueueDepth];
  logic [wsd_pkg::QueueAw-1:0]    wptr_q, rptr_q;
  logic [wsd_pkg::QueueCw-1:0]    cnt_q;
  logic                           do_wr, do_rd;

  assign full_o   = (cnt_q == wsd_pkg::QueueCw'(wsd_pkg::QueueDepth));
  assign valid_o  = (cnt_q != '0);
  assign do_wr    = wr_i & ~full_o;
  assign do_rd    = rd_i & valid_o;
  assign rd_cmd_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_rd) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/wsd_emitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_emitter
// Back end: unmasks queued items and holds the oldest result for the reader.
// ----------------------------------------------------------------------------
module wsd_emitter (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  wsd_pkg::cmd_t q_cmd_i,
  output logic          q_rd_o,
  input  logic          pop_i,
  output logic          empty_o,
  output wsd_pkg::cmd_t res_o
);

  logic          valid_q;
  wsd_pkg::cmd_t res_q, res_d;

  assign q_rd_o  = q_valid_i & (~valid_q | pop_i);
  assign empty_o = ~valid_q;
  assign res_o   = res_q;

  always_comb begin
    res_d      = q_cmd_i;
    res_d.data = q_cmd_i.has_byte ? (q_cmd_i.data ^ q_cmd_i.key) : 8'd0;
    res_d.key  = '0;
  end

  always_ff @(posedge clk_i) begin
    if (q_rd_o) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (q_rd_o) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

endmodule

// ===== hdl/websocket_frame_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Receive-side WebSocket frame parser: header decode, unmasking, control
// frame handling, streamed payload bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue side: drive rx_byte_i with push; a byte is taken at an edge
//   where push is high and full is low: one byte per cycle while not full.
//   Result queue side: while empty is low the oldest result sits on kind_o,
//   data_byte_o, has_byte_o, binary_o and last_o; pop takes it.
//   A byte that yields a result writes it into the queue as it is taken;
//   the output register takes it from the queue when free and drives the ports.
//   Rate is one byte per cycle, header and payload alike, while full is low;
//   a four-item queue sits between parser and emitter.
//   If the reader stalls, the queue fills and full rises until pops resume.
//   buffer_size_we_i / buffer_size_i set the largest accepted frame size.
//   Reset clears the parser to the first header byte, empties the queue and
//   restores buffer_size to 4096. After close or overflow all further bytes
//   are consumed and dropped until reset.
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  output logic                             full,
  input  logic [7:0]                       rx_byte_i,
  output logic                             empty,
  input  logic                             pop,
  output logic [2:0]                       kind_o,
  output logic [7:0]                       data_byte_o,
  output logic                             has_byte_o,
  output logic                             binary_o,
  output logic                             last_o,
  input  logic                             buffer_size_we_i,
  input  logic [wsd_pkg::BufSizeWidth-1:0] buffer_size_i
);

  logic          q_full;
  logic          accept;
  logic          emit;
  wsd_pkg::cmd_t cmd;
  logic          q_valid;
  logic          q_rd;
  wsd_pkg::cmd_t q_cmd;
  wsd_pkg::cmd_t res;

  assign full   = q_full;
  assign accept = push & ~q_full;

  wsd_parser u_parser (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .rx_byte_i        (rx_byte_i),
    .buffer_size_we_i (buffer_size_we_i),
    .buffer_size_i    (buffer_size_i),
    .emit_o           (emit),
    .cmd_o            (cmd)
  );

  wsd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (emit),
    .wr_cmd_i (cmd),
    .full_o   (q_full),
    .rd_i     (q_rd),
    .valid_o  (q_valid),
    .rd_cmd_o (q_cmd)
  );

  wsd_emitter u_emitter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_cmd_i   (q_cmd),
    .q_rd_o    (q_rd),
    .pop_i     (pop),
    .empty_o   (empty),
    .res_o     (res)
  );

  assign kind_o      = res.kind;
  assign data_byte_o = res.data;
  assign has_byte_o  = res.has_byte;
  assign binary_o    = res.binary;
  assign last_o      = res.last;

endmodule

// ===== hdl/wsd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_checker
// Port-level checks of the deframer's result queue, bound to the top level.
// ----------------------------------------------------------------------------
module wsd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [2:0] kind_o,
  input logic [7:0] data_byte_o,
  input logic       has_byte_o,
  input logic       binary_o,
  input logic       last_o
);

  a_empty_after_reset: assert property (@(posedge clk_i)
    disable iff (!rst_ni) !$past(rst_ni) |-> empty)
    else $error("result present right after reset");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(kind_o) && $stable(data_byte_o) &&
    $stable(has_byte_o) && $stable(binary_o) && $stable(last_o))
    else $error("stalled result changed");

  a_byte_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && has_byte_o |-> kind_o == wsd_pkg::KIND_DATA ||
    kind_o == wsd_pkg::KIND_PING)
    else $error("payload byte on a non-payload item");

  a_flags_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && kind_o != wsd_pkg::KIND_DATA && kind_o != wsd_pkg::KIND_PING
    |-> !has_byte_o && !binary_o && !last_o && data_byte_o == 8'd0)
    else $error("status item carries payload flags");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .empty       (empty),
  .pop         (pop),
  .kind_o      (kind_o),
  .data_byte_o (data_byte_o),
  .has_byte_o  (has_byte_o),
  .binary_o    (binary_o),
  .last_o      (last_o)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for websocket_frame_deframer. A short directed script
// and random frame streams are fed one byte per item. A byte-level model
// in this file tracks the header parser and predicts result items.
// Results are checked field by field, in order. Buffer size changes between
// phases, and the receiver stalls so that the input side fills up. The run
// ends on one close or overflow frame, and the bytes after it must be dropped.
// ----------------------------------------------------------------------------
module testbench;

  localparam int HOLD_CYCLES = 80;
  localparam int LATENCY_PAD = 8;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_BYTES = 115;

  typedef enum logic [1:0] {ROW_PRED, ROW_NONE, ROW_ONE} row_mode_e;
  typedef enum logic [2:0] {P_OPEN, P_LEN, P_EXT, P_KEY, P_BODY, P_HALT} parse_e;
  typedef enum logic [1:0] {BODY_DROP, BODY_DATA, BODY_PING} body_e;

  typedef struct packed {
    wsd_pkg::kind_e kind;
    logic [7:0]     data;
    logic           has;
    logic           bin;
    logic           last;
  } frame_out_t;

  typedef struct packed {
    logic [7:0] b;
    row_mode_e  mode;
    frame_out_t res;
  } stim_row_t;

  localparam frame_out_t NO_RES     = '0;
  localparam frame_out_t EMPTY_END  = '{wsd_pkg::KIND_DATA, 8'h00, 1'b0, 1'b0, 1'b1};
  localparam frame_out_t EMPTY_PING = '{wsd_pkg::KIND_PING, 8'h00, 1'b0, 1'b0, 1'b1};
  localparam frame_out_t BAD_OP     = '{wsd_pkg::KIND_UNKNOWN, 8'h00, 1'b0, 1'b0, 1'b0};
  localparam frame_out_t FRAG_ERR   = '{wsd_pkg::KIND_FRAG, 8'h00, 1'b0, 1'b0, 1'b0};
  localparam frame_out_t MASKED_00  = '{wsd_pkg::KIND_DATA, 8'h00, 1'b1, 1'b1, 1'b1};

  stim_row_t script [27] = '{
    '{8'h81, ROW_NONE, NO_RES},     '{8'h00, ROW_ONE, EMPTY_END},
    '{8'h89, ROW_NONE, NO_RES},     '{8'h00, ROW_ONE, EMPTY_PING},
    '{8'hF3, ROW_NONE, NO_RES},     '{8'h01, ROW_ONE, BAD_OP},
    '{8'hFF, ROW_NONE, NO_RES},
    '{8'h01, ROW_NONE, NO_RES},     '{8'h01, ROW_NONE, NO_RES},
    '{8'h41, ROW_PRED, NO_RES},
    '{8'h81, ROW_NONE, NO_RES},     '{8'h00, ROW_ONE, FRAG_ERR},
    '{8'h80, ROW_NONE, NO_RES},     '{8'h01, ROW_NONE, NO_RES},
    '{8'hFF, ROW_PRED, NO_RES},
    '{8'h80, ROW_NONE, NO_RES},     '{8'h00, ROW_ONE, EMPTY_END},
    '{8'h8A, ROW_NONE, NO_RES},     '{8'h01, ROW_NONE, NO_RES},
    '{8'h55, ROW_NONE, NO_RES},
    '{8'h82, ROW_NONE, NO_RES},     '{8'h81, ROW_NONE, NO_RES},
    '{8'hFF, ROW_NONE, NO_RES},     '{8'h00, ROW_NONE, NO_RES},
    '{8'h00, ROW_NONE, NO_RES},     '{8'h00, ROW_NONE, NO_RES},
    '{8'hFF, ROW_ONE, MASKED_00}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic [7:0] rx_byte_i = 8'h00;
  logic pop = 1'b0;
  logic buffer_size_we_i = 1'b0;
  logic [wsd_pkg::BufSizeWidth-1:0] buffer_size_i = '0;
  logic full;
  logic empty;
  logic [2:0] kind_o;
  logic [7:0] data_byte_o;
  logic has_byte_o;
  logic binary_o;
  logic last_o;

  row_mode_e cur_mode = ROW_PRED;
  frame_out_t cur_exp = '0;
  row_mode_e next_mode = ROW_PRED;
  frame_out_t next_res = '0;
  bit calm = 1'b0;
  bit hold_armed = 1'b0;
  bit hold_done = 1'b0;
  int bytes_sent = 0;
  int fails = 0;
  int idle_cycles = 0;
  frame_out_t pending_out [$];

  // model state
  logic [wsd_pkg::BufSizeWidth-1:0] frame_limit = wsd_pkg::BufSizeReset;
  parse_e      p_phase  = P_OPEN;
  logic [3:0]  p_left   = '0;
  logic [3:0]  p_hdr    = '0;
  logic [3:0]  p_op     = '0;
  logic        p_fin    = 1'b0;
  logic        p_masked = 1'b0;
  logic [63:0] p_remain = '0;
  logic [31:0] p_key    = '0;
  logic [1:0]  p_kidx   = '0;
  logic        p_frag   = 1'b0;
  logic        p_bin    = 1'b0;
  body_e       p_act    = BODY_DROP;

  websocket_frame_deframer DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .rx_byte_i        (rx_byte_i),
    .empty            (empty),
    .pop              (pop),
    .kind_o           (kind_o),
    .data_byte_o      (data_byte_o),
    .has_byte_o       (has_byte_o),
    .binary_o         (binary_o),
    .last_o           (last_o),
    .buffer_size_we_i (buffer_size_we_i),
    .buffer_size_i    (buffer_size_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit header_verdict(output frame_out_t r);
    logic [63:0] cap;
    logic [63:0] hdr;
    cap = 64'(frame_limit);
    hdr = 64'(p_hdr);
    r = '0;
    if (cap < hdr || p_remain > cap - hdr) begin
      p_phase = P_HALT;
      r.kind = wsd_pkg::KIND_OVERFLOW;
      return 1'b1;
    end
    p_phase = (p_remain != 0) ? P_BODY : P_OPEN;
    p_act = BODY_DROP;
    if (p_op <= wsd_pkg::OP_BINARY) begin
      if (p_op != wsd_pkg::OP_CONT && p_frag) begin
        r.kind = wsd_pkg::KIND_FRAG;
        return 1'b1;
      end
      if (p_op != wsd_pkg::OP_CONT) begin
        p_bin = (p_op == wsd_pkg::OP_BINARY);
        p_frag = !p_fin;
      end else if (p_fin) begin
        p_frag = 1'b0;
      end
      p_act = BODY_DATA;
      if (p_remain == 0 && p_fin) begin
        r.kind = wsd_pkg::KIND_DATA;
        r.bin = p_bin;
        r.last = 1'b1;
        return 1'b1;
      end
      return 1'b0;
    end
    if (p_op == wsd_pkg::OP_CLOSE) begin
      p_phase = P_HALT;
      r.kind = wsd_pkg::KIND_CLOSE;
      return 1'b1;
    end
    if (p_op == wsd_pkg::OP_PING) begin
      p_act = BODY_PING;
      if (p_remain == 0) begin
        r.kind = wsd_pkg::KIND_PING;
        r.last = 1'b1;
        return 1'b1;
      end
      return 1'b0;
    end
    if (p_op == wsd_pkg::OP_PONG) return 1'b0;
    r.kind = wsd_pkg::KIND_UNKNOWN;
    return 1'b1;
  endfunction

  function automatic bit length_known(output frame_out_t r);
    r = '0;
    if (p_masked) begin
      p_left = 4'd4;
      p_hdr = p_hdr + 4'd4;
      p_phase = P_KEY;
      return 1'b0;
    end
    return header_verdict(r);
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, output frame_out_t r);
    logic [6:0] len7;
    logic [7:0] kb;
    r = '0;
    case (p_phase)
      P_OPEN: begin
        p_fin = b[7];
        p_op = b[3:0];
        p_key = '0;
        p_kidx = '0;
        p_remain = '0;
        p_hdr = 4'd2;
        p_phase = P_LEN;
        return 1'b0;
      end
      P_LEN: begin
        p_masked = b[7];
        len7 = b[6:0];
        if (len7 == wsd_pkg::LEN_EXT16 || len7 == wsd_pkg::LEN_EXT64) begin
          p_left = (len7 == wsd_pkg::LEN_EXT16) ? 4'd2 : 4'd8;
          p_hdr = p_hdr + p_left;
          p_phase = P_EXT;
          return 1'b0;
        end
        p_remain = 64'(len7);
        return length_known(r);
      end
      P_EXT: begin
        p_remain = {p_remain[55:0], b};
        p_left = p_left - 4'd1;
        if (p_left == 0) return length_known(r);
        return 1'b0;
      end
      P_KEY: begin
        p_key = {p_key[23:0], b};
        p_left = p_left - 4'd1;
        if (p_left == 0) return header_verdict(r);
        return 1'b0;
      end
      P_BODY: begin
        kb = p_key[8*(3-p_kidx) +: 8];
        p_kidx = p_kidx + 2'd1;
        p_remain = p_remain - 64'd1;
        if (p_remain == 0) p_phase = P_OPEN;
        r.data = b ^ kb;
        r.has = 1'b1;
        if (p_act == BODY_DATA) begin
          r.kind = wsd_pkg::KIND_DATA;
          r.bin = p_bin;
          r.last = (p_remain == 0) && p_fin;
          return 1'b1;
        end
        if (p_act == BODY_PING) begin
          r.kind = wsd_pkg::KIND_PING;
          r.last = (p_remain == 0);
          return 1'b1;
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk_i) begin : monitor
    frame_out_t pred;
    frame_out_t want;
    bit made;
    if (rst_ni) begin
      if (buffer_size_we_i) frame_limit = buffer_size_i;
      if (push && !full) begin
        made = deframe_byte(rx_byte_i, pred);
        if (cur_mode == ROW_PRED && made) pending_out = {pending_out, pred};
        else if (cur_mode == ROW_ONE) pending_out = {pending_out, cur_exp};
      end
      if (pop && !empty) begin
        if (pending_out.size() == 0) begin
          $error("result with no item pending: kind %0d byte %02h", kind_o, data_byte_o);
          fails++;
        end else begin
          want = pending_out.pop_front();
          if (kind_o !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind_o);
            fails++;
          end
          if (data_byte_o !== want.data) begin
            $error("data_byte: expected %02h, got %02h", want.data, data_byte_o);
            fails++;
          end
          if (has_byte_o !== want.has) begin
            $error("has_byte: expected %0b, got %0b", want.has, has_byte_o);
            fails++;
          end
          if (binary_o !== want.bin) begin
            $error("binary: expected %0b, got %0b", want.bin, binary_o);
            fails++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last_o);
            fails++;
          end
        end
      end
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : reader
    int n;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        pop <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 9);
        pop <= 1'b0;
        repeat (n) @(negedge clk_i);
        pop <= 1'b1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push <= 1'b1;
    rx_byte_i <= b;
    cur_mode <= next_mode;
    cur_exp <= next_res;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_frame(input logic [3:0] opc, input bit fin, input bit msk,
                            input int form, input logic [63:0] len, input int nbody);
    logic [6:0] len7;
    int i;
    len7 = (form == 0) ? len[6:0] :
           (form == 1) ? wsd_pkg::LEN_EXT16 : wsd_pkg::LEN_EXT64;
    send_byte({fin, 3'($urandom), opc});
    send_byte({msk, len7});
    if (form == 1) begin
      send_byte(len[15:8]);
      send_byte(len[7:0]);
    end else if (form == 2) begin
      for (i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
    end
    if (msk) for (i = 0; i < 4; i++) send_byte(8'($urandom));
    for (i = 0; i < nbody; i++) send_byte(8'($urandom));
  endtask

  task automatic random_frame(input int bsz);
    int sel, form, hdr, cap, plen, r;
    logic [3:0] opc;
    bit fin, msk;
    sel = $urandom_range(0, 99);
    if (sel < 25) opc = wsd_pkg::OP_TEXT;
    else if (sel < 50) opc = wsd_pkg::OP_BINARY;
    else if (sel < 70) opc = wsd_pkg::OP_CONT;
    else if (sel < 80) opc = wsd_pkg::OP_PING;
    else if (sel < 86) opc = wsd_pkg::OP_PONG;
    else begin
      r = $urandom_range(0, 9);
      opc = (r < 5) ? 4'(3 + r) : 4'(11 + r - 5);
    end
    fin = ($urandom_range(0, 9) < 7);
    msk = 1'($urandom_range(0, 1));
    sel = $urandom_range(0, 99);
    if (sel < 87) plen = $urandom_range(0, 12);
    else if (sel < 97) plen = $urandom_range(13, 40);
    else plen = $urandom_range(126, 300);
    if (opc == wsd_pkg::OP_PING && $urandom_range(0, 3) == 0) plen = $urandom_range(126, 200);
    if (plen > 125) form = $urandom_range(1, 2);
    else form = ($urandom_range(0, 9) < 8) ? 0 : $urandom_range(1, 2);
    hdr = 2 + ((form == 1) ? 2 : (form == 2) ? 8 : 0) + (msk ? 4 : 0);
    cap = bsz - hdr;
    if (plen > cap) plen = cap;
    if ($urandom_range(0, 19) == 0 && cap <= 300 && (cap <= 125 || form != 0)) plen = cap;
    send_frame(opc, fin, msk, form, 64'(plen), plen);
  endtask

  task automatic settle();
    push <= 1'b0;
    @(negedge clk_i);
    while (pending_out.size() != 0) @(negedge clk_i);
    repeat (LATENCY_PAD) @(negedge clk_i);
  endtask

  task automatic set_buffer(input logic [wsd_pkg::BufSizeWidth-1:0] v);
    buffer_size_i <= v;
    buffer_size_we_i <= 1'b1;
    @(negedge clk_i);
    buffer_size_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    int sizes [8];
    int ph, quota, term, hdr, waited;
    bit msk;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (script[i]) begin
      next_mode = script[i].mode;
      next_res = script[i].res;
      send_byte(script[i].b);
    end
    next_mode = ROW_PRED;
    next_res = NO_RES;

    sizes[0] = 16;
    sizes[1] = 1048576;
    sizes[2] = 32'h001F_FFFF;
    sizes[3] = $urandom_range(17, 64);
    sizes[4] = $urandom_range(16, 1048576);
    sizes[5] = 4096;
    sizes[6] = $urandom_range(65, 4096);
    sizes[7] = $urandom_range(16, 4096);

    for (ph = 0; ph < 8; ph++) begin
      settle();
      calm <= (ph == 7) || ($urandom_range(0, 3) == 0);
      set_buffer(sizes[ph][wsd_pkg::BufSizeWidth-1:0]);
      if (ph == 1) begin
        hold_armed <= 1'b1;
        send_frame(wsd_pkg::OP_BINARY, 1'b1, 1'b0, 1, 64'd200, 200);
      end
      quota = bytes_sent + PHASE_BYTES;
      while (bytes_sent < quota) random_frame(sizes[ph]);
    end

    // stream ends with close or overflow; everything after must be dropped
    term = $urandom_range(0, 2);
    msk = 1'($urandom_range(0, 1));
    if (term == 0) begin
      send_frame(wsd_pkg::OP_CLOSE, 1'($urandom_range(0, 1)), msk, 0,
                 64'($urandom_range(0, 5)), $urandom_range(0, 5));
    end else if (term == 1) begin
      send_frame(wsd_pkg::OP_BINARY, 1'b1, msk, 2,
                 {1'b1, 31'($urandom), 32'($urandom)}, 4);
    end else begin
      hdr = 4 + (msk ? 4 : 0);
      send_frame(wsd_pkg::OP_TEXT, 1'b1, msk, 1, 64'(sizes[7] - hdr + 1), 3);
    end
    repeat (6) send_byte(8'($urandom));
    send_byte(8'h81);
    send_byte(8'h00);

    push <= 1'b0;
    waited = 0;
    while (pending_out.size() != 0 && waited < 1000) begin
      @(negedge clk_i);
      waited++;
    end
    if (pending_out.size() != 0) begin
      $error("%0d expected results never arrived", pending_out.size());
      fails++;
    end
    repeat (16) @(negedge clk_i);
    if (fails == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/wsd_pkg.sv
hdl/wsd_parser.sv
hdl/wsd_queue.sv
hdl/wsd_emitter.sv
hdl/websocket_frame_deframer.sv
hdl/wsd_checker.sv
verif/testbench.sv
